>>> rtl/core/dmpid_pkg.sv
// Shared types, widths, register map and reset values for the dual motor PID drive.
package dmpid_pkg;

  localparam int ENC_W    = 16;
  localparam int TGT_W    = 21;
  localparam int SUM_W    = 21;
  localparam int ERR_W    = 22;
  localparam int CMD_W    = 24;
  localparam int PWM_W    = 14;
  localparam int GAIN_W   = 16;
  localparam int SPD_W    = 20;
  localparam int TICK_W   = 6;
  localparam int PLIM_W   = 13;
  localparam int DZ_W     = 10;
  localparam int VOLT_W   = 16;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam int D1_W     = ERR_W + 1;
  localparam int D2_W     = ERR_W + 3;
  localparam int PP_W     = GAIN_W + 1 + D1_W;
  localparam int PI_W     = GAIN_W + 1 + ERR_W;
  localparam int PD_W     = GAIN_W + 1 + D2_W;
  localparam int ACC_W    = PD_W + 2;
  localparam int FRAC_W   = 8;
  localparam int INC_W    = ACC_W - FRAC_W;
  localparam int CSUM_W   = INC_W + 1;

  localparam logic [GAIN_W-1:0] KP_RESET       = 16'd372;
  localparam logic [GAIN_W-1:0] KI_RESET       = 16'd148;
  localparam logic [GAIN_W-1:0] KD_RESET       = 16'd0;
  localparam logic [SPD_W-1:0]  SPEED_RESET    = 20'd1000;
  localparam logic [TICK_W-1:0] TICKS_RESET    = 6'd40;
  localparam logic [PLIM_W-1:0] PWM_LIM_RESET  = 13'd6900;
  localparam logic [DZ_W-1:0]   DZ_RESET       = 10'd100;
  localparam logic [VOLT_W-1:0] LOW_VOLT_RESET = 16'd1110;

  localparam logic [1:0] DRIVE_OFF = 2'd0;
  localparam logic [1:0] DRIVE_FWD = 2'd1;
  localparam logic [1:0] DRIVE_REV = 2'd2;

  typedef enum logic [2:0] {
    REG_KP        = 3'd0,
    REG_KI        = 3'd1,
    REG_KD        = 3'd2,
    REG_SPEED     = 3'd3,
    REG_TICKS     = 3'd4,
    REG_PWM_LIMIT = 3'd5,
    REG_DEADZONE  = 3'd6,
    REG_LOW_VOLT  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp_gain;
    logic [GAIN_W-1:0] ki_gain;
    logic [GAIN_W-1:0] kd_gain;
    logic [SPD_W-1:0]  speed_limit;
    logic [TICK_W-1:0] ticks_per_period;
    logic [PLIM_W-1:0] pwm_limit;
    logic [DZ_W-1:0]   deadzone_offset;
    logic [VOLT_W-1:0] low_voltage;
  } cfg_t;

  typedef struct packed {
    logic ld2;
    logic ld3;
    logic stop;
    logic low;
  } wheel_ctl_t;

endpackage

>>> rtl/core/dmpid_cfg.sv
// APB configuration register file for the dual motor PID drive.
module dmpid_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dmpid_pkg::ADDR_W-1:0]  paddr,
  input  logic [dmpid_pkg::DATA_W-1:0]  pwdata,
  output logic [dmpid_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  output dmpid_pkg::cfg_t               cfg
);
  import dmpid_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_KP:        cfg_nxt.kp_gain          = pwdata[GAIN_W-1:0];
        REG_KI:        cfg_nxt.ki_gain          = pwdata[GAIN_W-1:0];
        REG_KD:        cfg_nxt.kd_gain          = pwdata[GAIN_W-1:0];
        REG_SPEED:     cfg_nxt.speed_limit      = pwdata[SPD_W-1:0];
        REG_TICKS:     cfg_nxt.ticks_per_period = pwdata[TICK_W-1:0];
        REG_PWM_LIMIT: cfg_nxt.pwm_limit        = pwdata[PLIM_W-1:0];
        REG_DEADZONE:  cfg_nxt.deadzone_offset  = pwdata[DZ_W-1:0];
        REG_LOW_VOLT:  cfg_nxt.low_voltage      = pwdata[VOLT_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_KP:        prdata[GAIN_W-1:0] = cfg_r.kp_gain;
      REG_KI:        prdata[GAIN_W-1:0] = cfg_r.ki_gain;
      REG_KD:        prdata[GAIN_W-1:0] = cfg_r.kd_gain;
      REG_SPEED:     prdata[SPD_W-1:0]  = cfg_r.speed_limit;
      REG_TICKS:     prdata[TICK_W-1:0] = cfg_r.ticks_per_period;
      REG_PWM_LIMIT: prdata[PLIM_W-1:0] = cfg_r.pwm_limit;
      REG_DEADZONE:  prdata[DZ_W-1:0]   = cfg_r.deadzone_offset;
      REG_LOW_VOLT:  prdata[VOLT_W-1:0] = cfg_r.low_voltage;
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp_gain          <= KP_RESET;
      cfg_r.ki_gain          <= KI_RESET;
      cfg_r.kd_gain          <= KD_RESET;
      cfg_r.speed_limit      <= SPEED_RESET;
      cfg_r.ticks_per_period <= TICKS_RESET;
      cfg_r.pwm_limit        <= PWM_LIM_RESET;
      cfg_r.deadzone_offset  <= DZ_RESET;
      cfg_r.low_voltage      <= LOW_VOLT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> rtl/core/dmpid_wheel.sv
// Incremental PID, command saturation and PWM/direction output for one wheel.
module dmpid_wheel (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dmpid_pkg::cfg_t                     cfg,
  input  dmpid_pkg::wheel_ctl_t               ctl,
  input  logic signed [dmpid_pkg::SUM_W-1:0]  meas,
  input  logic signed [dmpid_pkg::TGT_W-1:0]  target,
  output logic        [dmpid_pkg::PWM_W-1:0]  pwm,
  output logic        [1:0]                   drive
);
  import dmpid_pkg::*;

  localparam logic signed [CMD_W-1:0] CMD_POS = {1'b0, {(CMD_W-1){1'b1}}};
  localparam logic signed [CMD_W-1:0] CMD_NEG = {1'b1, {(CMD_W-1){1'b0}}};

  logic signed [ERR_W-1:0]  last_err_r, prev_err_r;
  logic signed [ERR_W-1:0]  err;
  logic signed [D1_W-1:0]   d1;
  logic signed [D2_W-1:0]   d2;
  logic signed [PP_W-1:0]   prod_p_r, prod_p_nxt;
  logic signed [PI_W-1:0]   prod_i_r, prod_i_nxt;
  logic signed [PD_W-1:0]   prod_d_r, prod_d_nxt;

  logic signed [ACC_W-1:0]  acc, acc_adj;
  logic signed [INC_W-1:0]  inc;
  logic signed [CSUM_W-1:0] csum;
  logic signed [CMD_W-1:0]  cmd_r, cmd_sat, cmd_new, cmd_clip, lim_pos, lim_neg;
  logic        [CMD_W-1:0]  cmd_abs;
  logic        [PWM_W-1:0]  held_pwm_r, pwm_new;
  logic        [PWM_W-1:0]  pwm_r, pwm_nxt;
  logic        [1:0]        drive_r, drive_nxt;
  logic                     drive_off;

  assign err = ERR_W'(target) - ERR_W'(meas);
  assign d1  = D1_W'(err) - D1_W'(last_err_r);
  assign d2  = D2_W'(err) - (D2_W'(last_err_r) <<< 1) + D2_W'(prev_err_r);

  assign prod_p_nxt = PP_W'($signed({1'b0, cfg.kp_gain})) * PP_W'(d1);
  assign prod_i_nxt = PI_W'($signed({1'b0, cfg.ki_gain})) * PI_W'(err);
  assign prod_d_nxt = PD_W'($signed({1'b0, cfg.kd_gain})) * PD_W'(d2);

  always_comb begin
    acc     = ACC_W'(prod_p_r) + ACC_W'(prod_i_r) + ACC_W'(prod_d_r);
    acc_adj = acc[ACC_W-1] ? acc + ACC_W'((1 << FRAC_W) - 1) : acc;
    inc     = acc_adj[ACC_W-1:FRAC_W];
    csum    = CSUM_W'(cmd_r) + CSUM_W'(inc);
    if (csum > CSUM_W'(CMD_POS)) begin
      cmd_sat = CMD_POS;
    end else if (csum < CSUM_W'(CMD_NEG)) begin
      cmd_sat = CMD_NEG;
    end else begin
      cmd_sat = csum[CMD_W-1:0];
    end
    cmd_new = ctl.stop ? '0 : cmd_sat;

    lim_pos = CMD_W'({1'b0, cfg.pwm_limit});
    lim_neg = -lim_pos;
    if (cmd_new > lim_pos) begin
      cmd_clip = lim_pos;
    end else if (cmd_new < lim_neg) begin
      cmd_clip = lim_neg;
    end else begin
      cmd_clip = cmd_new;
    end
    cmd_abs = cmd_clip[CMD_W-1] ? CMD_W'(-cmd_clip) : CMD_W'(cmd_clip);
    pwm_new = PWM_W'(cmd_abs[PLIM_W-1:0]) + PWM_W'(cfg.deadzone_offset);

    drive_off = ctl.stop || ctl.low;
    if (drive_off) begin
      pwm_nxt   = held_pwm_r;
      drive_nxt = DRIVE_OFF;
    end else begin
      pwm_nxt   = pwm_new;
      drive_nxt = cmd_clip[CMD_W-1] ? DRIVE_REV : DRIVE_FWD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r <= '0;
      prev_err_r <= '0;
      cmd_r      <= '0;
      held_pwm_r <= '0;
    end else begin
      if (ctl.ld2) begin
        last_err_r <= err;
        prev_err_r <= last_err_r;
      end
      if (ctl.ld3) begin
        cmd_r <= drive_off ? cmd_new : cmd_clip;
        if (!drive_off) begin
          held_pwm_r <= pwm_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      prod_p_r <= prod_p_nxt;
      prod_i_r <= prod_i_nxt;
      prod_d_r <= prod_d_nxt;
    end
    if (ctl.ld3) begin
      pwm_r   <= pwm_nxt;
      drive_r <= drive_nxt;
    end
  end

  assign pwm   = pwm_r;
  assign drive = drive_r;

endmodule

>>> rtl/core/dual_motor_incremental_pid_drive_top.sv
// Top level of the dual motor incremental PID drive.
//
// The input channel takes one sample tick per transaction: two raw encoder
// deltas, two speed targets, a stop flag and the battery voltage. Encoder
// deltas are summed as each transaction is accepted, the left one subtracted;
// only the tick that closes a control period produces a result transaction,
// all other ticks produce none. A period-closing tick runs through three
// register stages: capture and target clamping, the three gain
// multiplications, then the PID sum, command saturation and PWM formatting.
// One input transaction can be accepted in every cycle in which the input
// is not stalled. Each stage holds its item only while the stage behind it
// is full and stalled, so input stalls only when all three stages are
// occupied and the receiver is stalling. Synchronous reset clears the tick
// count, encoder sums, error history, commands, held PWM values and all
// stage valid bits, and loads the configuration registers with their
// defaults. Configuration is written through the APB port, which is always
// ready.
module dual_motor_incremental_pid_drive_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [dmpid_pkg::ENC_W-1:0]  in_enc_left_raw,
  input  logic signed [dmpid_pkg::ENC_W-1:0]  in_enc_right_raw,
  input  logic signed [dmpid_pkg::TGT_W-1:0]  in_target_left,
  input  logic signed [dmpid_pkg::TGT_W-1:0]  in_target_right,
  input  logic                                in_stop,
  input  logic        [dmpid_pkg::VOLT_W-1:0] in_battery_centivolts,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic        [dmpid_pkg::PWM_W-1:0]  out_pwm_left,
  output logic        [1:0]                   out_drive_left,
  output logic        [dmpid_pkg::PWM_W-1:0]  out_pwm_right,
  output logic        [1:0]                   out_drive_right,
  output logic signed [dmpid_pkg::SUM_W-1:0]  out_measured_left,
  output logic signed [dmpid_pkg::SUM_W-1:0]  out_measured_right,
  output logic                                out_over_limit,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic        [dmpid_pkg::ADDR_W-1:0] paddr,
  input  logic        [dmpid_pkg::DATA_W-1:0] pwdata,
  output logic        [dmpid_pkg::DATA_W-1:0] prdata,
  output logic                                pready
);
  import dmpid_pkg::*;

  localparam int SACC_W = SUM_W + 2;
  localparam int LIM_W  = SPD_W + 2;
  localparam logic signed [SUM_W-1:0] SUM_POS = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_NEG = {1'b1, {(SUM_W-1){1'b0}}};

  cfg_t       cfg;
  wheel_ctl_t ctl;

  logic [TICK_W-1:0] tick_r, tick_nxt, period;
  logic signed [SUM_W-1:0] sum_left_r, sum_right_r, sum_left_nxt, sum_right_nxt;
  logic signed [SUM_W-1:0] sum_left_sat, sum_right_sat;
  logic signed [SACC_W-1:0] sacc_left, sacc_right;
  logic signed [LIM_W-1:0]  lim_pos, lim_neg, tl_ext, tr_ext;
  logic signed [TGT_W-1:0]  tl_clip, tr_clip;
  logic        over_nxt, low_nxt;
  logic        accept, period_end;

  logic        v1_r, v2_r, out_valid_r;
  logic        v1_nxt, v2_nxt, out_valid_nxt;
  logic        en1, en2, en3;
  logic signed [SUM_W-1:0] ml1_r, mr1_r, ml2_r, mr2_r;
  logic signed [TGT_W-1:0] tl1_r, tr1_r;
  logic        stop1_r, low1_r, over1_r, stop2_r, low2_r, over2_r;
  logic signed [SUM_W-1:0] out_ml_r, out_mr_r;
  logic        out_over_r;

  dmpid_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign en3      = !out_valid_r || !out_stall;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;
  assign accept   = in_valid && en1;

  always_comb begin
    period    = (cfg.ticks_per_period == '0) ? TICK_W'(1) : cfg.ticks_per_period;
    tick_nxt  = tick_r + TICK_W'(1);
    period_end = tick_nxt >= period;

    sacc_left  = SACC_W'(sum_left_r) - SACC_W'(in_enc_left_raw);
    sacc_right = SACC_W'(sum_right_r) + SACC_W'(in_enc_right_raw);
    if (sacc_left > SACC_W'(SUM_POS)) begin
      sum_left_sat = SUM_POS;
    end else if (sacc_left < SACC_W'(SUM_NEG)) begin
      sum_left_sat = SUM_NEG;
    end else begin
      sum_left_sat = sacc_left[SUM_W-1:0];
    end
    if (sacc_right > SACC_W'(SUM_POS)) begin
      sum_right_sat = SUM_POS;
    end else if (sacc_right < SACC_W'(SUM_NEG)) begin
      sum_right_sat = SUM_NEG;
    end else begin
      sum_right_sat = sacc_right[SUM_W-1:0];
    end

    lim_pos = LIM_W'({1'b0, cfg.speed_limit});
    lim_neg = -lim_pos;
    tl_ext  = LIM_W'(in_target_left);
    tr_ext  = LIM_W'(in_target_right);
    over_nxt = (tl_ext > lim_pos) || (tl_ext < lim_neg) ||
               (tr_ext > lim_pos) || (tr_ext < lim_neg);
    if (tl_ext > lim_pos) begin
      tl_clip = lim_pos[TGT_W-1:0];
    end else if (tl_ext < lim_neg) begin
      tl_clip = lim_neg[TGT_W-1:0];
    end else begin
      tl_clip = in_target_left;
    end
    if (tr_ext > lim_pos) begin
      tr_clip = lim_pos[TGT_W-1:0];
    end else if (tr_ext < lim_neg) begin
      tr_clip = lim_neg[TGT_W-1:0];
    end else begin
      tr_clip = in_target_right;
    end
    low_nxt = in_battery_centivolts < cfg.low_voltage;

    sum_left_nxt  = period_end ? '0 : sum_left_sat;
    sum_right_nxt = period_end ? '0 : sum_right_sat;

    v1_nxt        = en1 ? (accept && period_end) : v1_r;
    v2_nxt        = en2 ? v1_r : v2_r;
    out_valid_nxt = en3 ? v2_r : out_valid_r;
  end

  assign ctl.ld2  = v1_r && en2;
  assign ctl.ld3  = v2_r && en3;
  assign ctl.stop = stop2_r;
  assign ctl.low  = low2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= '0;
      sum_left_r  <= '0;
      sum_right_r <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        tick_r      <= period_end ? '0 : tick_nxt;
        sum_left_r  <= sum_left_nxt;
        sum_right_r <= sum_right_nxt;
      end
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && period_end) begin
      ml1_r   <= sum_left_sat;
      mr1_r   <= sum_right_sat;
      tl1_r   <= tl_clip;
      tr1_r   <= tr_clip;
      stop1_r <= in_stop;
      low1_r  <= low_nxt;
      over1_r <= over_nxt;
    end
    if (ctl.ld2) begin
      ml2_r   <= ml1_r;
      mr2_r   <= mr1_r;
      stop2_r <= stop1_r;
      low2_r  <= low1_r;
      over2_r <= over1_r;
    end
    if (ctl.ld3) begin
      out_ml_r   <= ml2_r;
      out_mr_r   <= mr2_r;
      out_over_r <= over2_r;
    end
  end

  dmpid_wheel u_wheel_left (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .ctl    (ctl),
    .meas   (ml1_r),
    .target (tl1_r),
    .pwm    (out_pwm_left),
    .drive  (out_drive_left)
  );

  dmpid_wheel u_wheel_right (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .ctl    (ctl),
    .meas   (mr1_r),
    .target (tr1_r),
    .pwm    (out_pwm_right),
    .drive  (out_drive_right)
  );

  assign out_valid          = out_valid_r;
  assign out_measured_left  = out_ml_r;
  assign out_measured_right = out_mr_r;
  assign out_over_limit     = out_over_r;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && out_valid_r && out_stall))
    else $error("input stalled while a pipeline stage was free");

  a_period_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && period_end) |=> (tick_r == '0 && sum_left_r == '0 && sum_right_r == '0))
    else $error("period end did not restart the tick count and sums");

  a_stop_turns_off: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.ld3 && stop2_r) |=> (out_drive_left == DRIVE_OFF && out_drive_right == DRIVE_OFF))
    else $error("stop did not turn both drives off");

  a_pwm_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_drive_left != DRIVE_OFF) |->
      (out_pwm_left >= PWM_W'(cfg.deadzone_offset) &&
       out_pwm_left <= PWM_W'(cfg.pwm_limit) + PWM_W'(cfg.deadzone_offset)))
    else $error("left pwm outside deadzone and limit range");

  a_pwm_right_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_drive_right != DRIVE_OFF) |->
      (out_pwm_right >= PWM_W'(cfg.deadzone_offset) &&
       out_pwm_right <= PWM_W'(cfg.pwm_limit) + PWM_W'(cfg.deadzone_offset)))
    else $error("right pwm outside deadzone and limit range");
`endif

endmodule
